// File: rtl/core/bitmap_block_allocator_assert.svh
// ---------------------------------------------------------------------------
// bitmap_block_allocator_assert.svh
// assertion macros used by the allocator checker
// ---------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("bitmap_block_allocator assertion failed");

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bitmap_block_allocator assertion failed");

`endif

// File: rtl/core/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// types and codes of the bitmap block allocator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOFIT    = 2'd1,
		ST_NOTSTART = 2'd2,
		ST_ZERO     = 2'd3
	} status_t;

	typedef struct packed {
		logic       mode;
		logic [6:0] block_count;
		logic [5:0] start_block;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] run_start;
		logic [6:0] blocks_released;
		logic [6:0] free_blocks;
	} rsp_t;

	typedef struct packed {
		logic set_alloc;
		logic clr_alloc;
		logic set_start;
		logic clr_start;
	} map_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/bba_stream_if.sv
// ---------------------------------------------------------------------------
// bba_stream_if
// valid/ready channel carrying one word of type T
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bba_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bba_maps.sv
// ---------------------------------------------------------------------------
// bba_maps
// allocated and run-start bitmaps with one read and one write index
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_maps import bba_pkg::*; #(
	parameter int BLOCKS = 64,
	localparam int IDX_W = $clog2(BLOCKS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] rd_idx,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire map_cmd_t         cmd,
	output logic                  alloc_bit,
	output logic                  start_bit
);

	logic [BLOCKS-1:0] alloc_map_q;
	logic [BLOCKS-1:0] start_map_q;

	assign alloc_bit = alloc_map_q[rd_idx];
	assign start_bit = start_map_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_map_q <= '0;
			start_map_q <= '0;
		end else begin
			if (cmd.set_alloc) begin
				alloc_map_q[wr_idx] <= 1'b1;
			end else if (cmd.clr_alloc) begin
				alloc_map_q[wr_idx] <= 1'b0;
			end
			if (cmd.set_start) begin
				start_map_q[wr_idx] <= 1'b1;
			end else if (cmd.clr_start) begin
				start_map_q[wr_idx] <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bba_ctrl.sv
// ---------------------------------------------------------------------------
// bba_ctrl
// sequencer stepping one bitmap index per cycle for search, mark and walk
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl import bba_pkg::*; #(
	parameter int BLOCKS = 64,
	localparam int IDX_W = $clog2(BLOCKS),
	localparam int CNT_W = $clog2(BLOCKS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire req_t             req_data,
	output logic [IDX_W-1:0]      rd_idx,
	output logic [IDX_W-1:0]      wr_idx,
	output map_cmd_t              cmd,
	input  wire logic             alloc_bit,
	input  wire logic             start_bit,
	output logic                  res_valid,
	output rsp_t                  res,
	input  wire logic             res_take
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_MARK   = 5'b00100,
		S_WALK   = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] start_q;
	logic [CNT_W-1:0] run_q;
	logic [CNT_W-1:0] need_q;
	logic [CNT_W-1:0] rel_q;
	logic [CNT_W-1:0] avail_q;
	rsp_t             res_q;

	logic             accept;
	logic             sblk_ok;
	logic             last;
	logic             walk_stop;
	logic             fit;
	logic [IDX_W-1:0] i_inc;
	logic [IDX_W-1:0] st_sel;
	logic [CNT_W-1:0] run_inc;
	logic [CNT_W-1:0] rel_inc;
	logic [CNT_W-1:0] rel_fin;
	logic [CNT_W-1:0] avail_add;
	logic [CNT_W-1:0] avail_sub;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign sblk_ok   = int'(req_data.start_block) < BLOCKS;
	assign rd_idx    = (state_q == S_IDLE) ? IDX_W'(req_data.start_block) : i_q;
	assign last      = (i_q == IDX_W'(BLOCKS - 1));
	assign i_inc     = i_q + IDX_W'(1);
	assign run_inc   = run_q + CNT_W'(1);
	assign rel_inc   = rel_q + CNT_W'(1);
	assign st_sel    = (run_q == '0) ? i_q : start_q;
	assign fit       = !alloc_bit && (run_inc == need_q);
	assign walk_stop = start_bit || !alloc_bit;
	assign rel_fin   = walk_stop ? rel_q : rel_inc;
	assign avail_add = avail_q + rel_fin;
	assign avail_sub = avail_q - need_q;
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	always_comb begin
		cmd    = '0;
		wr_idx = i_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req_data.mode == MODE_FREE && sblk_ok && start_bit) begin
					cmd.clr_start = 1'b1;
					wr_idx        = rd_idx;
				end
			end
			S_SEARCH: begin
				if (fit) begin
					cmd.set_start = 1'b1;
					wr_idx        = st_sel;
				end
			end
			S_MARK: begin
				cmd.set_alloc = 1'b1;
			end
			S_WALK: begin
				cmd.clr_alloc = !walk_stop;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			start_q <= '0;
			run_q   <= '0;
			need_q  <= '0;
			rel_q   <= '0;
			avail_q <= CNT_W'(BLOCKS);
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q.run_start       <= '0;
						res_q.blocks_released <= '0;
						res_q.free_blocks     <= 7'(avail_q);
						if (req_data.mode == MODE_ALLOC) begin
							if (req_data.block_count == '0) begin
								res_q.status <= ST_ZERO;
								state_q      <= S_RESP;
							end else if (int'(req_data.block_count) > int'(avail_q)) begin
								res_q.status <= ST_NOFIT;
								state_q      <= S_RESP;
							end else begin
								need_q  <= CNT_W'(req_data.block_count);
								i_q     <= '0;
								run_q   <= '0;
								state_q <= S_SEARCH;
							end
						end else begin
							if (!sblk_ok || !start_bit) begin
								res_q.status <= ST_NOTSTART;
								state_q      <= S_RESP;
							end else begin
								i_q     <= rd_idx;
								rel_q   <= '0;
								state_q <= S_WALK;
							end
						end
					end
				end
				S_SEARCH: begin
					if (fit) begin
						start_q <= st_sel;
						i_q     <= st_sel;
						run_q   <= need_q;
						state_q <= S_MARK;
					end else if (last) begin
						res_q.status <= ST_NOFIT;
						state_q      <= S_RESP;
					end else begin
						i_q <= i_inc;
						if (alloc_bit) begin
							run_q <= '0;
						end else begin
							run_q   <= run_inc;
							start_q <= st_sel;
						end
					end
				end
				S_MARK: begin
					i_q   <= i_inc;
					run_q <= run_q - CNT_W'(1);
					if (run_q == CNT_W'(1)) begin
						avail_q           <= avail_sub;
						res_q.status      <= ST_OK;
						res_q.run_start   <= 6'(start_q);
						res_q.free_blocks <= 7'(avail_sub);
						state_q           <= S_RESP;
					end
				end
				S_WALK: begin
					if (walk_stop || last) begin
						avail_q               <= avail_add;
						res_q.status          <= ST_OK;
						res_q.blocks_released <= 7'(rel_fin);
						res_q.free_blocks     <= 7'(avail_add);
						state_q               <= S_RESP;
					end else begin
						rel_q <= rel_inc;
						i_q   <= i_inc;
					end
				end
				S_RESP: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bitmap_block_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit run allocator over one page of BLOCKS blocks
//
// allocate: a check on acceptance, a first-fit search of the bitmap and
//   marking of block_count blocks, one bitmap bit per cycle, then the word
//   is handed to the output register once that register is free or drains
// free: a check on acceptance, a walk over the run, then the response
// one request at a time; a finished word may wait in the output register
// reset clears both bitmaps and sets the free count to BLOCKS at once
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator import bba_pkg::*; #(
	parameter int BLOCKS = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bba_stream_if.sink   req,
	bba_stream_if.source rsp
);

	localparam int IDX_W = $clog2(BLOCKS);

	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;
	map_cmd_t         cmd;
	logic             alloc_bit;
	logic             start_bit;
	logic             res_valid;
	rsp_t             res;
	logic             res_take;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	bba_maps #(.BLOCKS(BLOCKS)) u_maps (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (rd_idx),
		.wr_idx    (wr_idx),
		.cmd       (cmd),
		.alloc_bit (alloc_bit),
		.start_bit (start_bit)
	);

	bba_ctrl #(.BLOCKS(BLOCKS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_data  (req.data),
		.rd_idx    (rd_idx),
		.wr_idx    (wr_idx),
		.cmd       (cmd),
		.alloc_bit (alloc_bit),
		.start_bit (start_bit),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	assign res_take  = res_valid && (!rsp_valid_q || rsp.ready);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bba_checker.sv
// ---------------------------------------------------------------------------
// bba_checker
// port-level checks of the bitmap block allocator, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_block_allocator_assert.svh"

module bba_checker import bba_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);

	`BBA_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
	`BBA_ASSERT_NXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)
	`BBA_ASSERT_IMP(a_fail_clean, clk, arst_n, rsp_valid && rsp_data.status != ST_OK, rsp_data.run_start == '0 && rsp_data.blocks_released == '0)
	`BBA_ASSERT_IMP(a_alloc_no_release, clk, arst_n, rsp_valid && rsp_data.run_start != '0, rsp_data.blocks_released == '0 && rsp_data.status == ST_OK)

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
